// File: design/i2c_tbe_pkg.sv
// Shared types and codes for the I2C target bus engine.
package i2c_tbe_pkg;

    localparam int unsigned AddrWidth = 7;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned CountWidth = 4;

    localparam logic [CountWidth-1:0] AddrBits = 4'd7;
    localparam logic [CountWidth-1:0] ByteBits = 4'd8;
    localparam logic [CountWidth-1:0] ReadSlot = 4'd9;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_START        = 3'd1,
        EV_STOP         = 3'd2,
        EV_READ_SEL     = 3'd3,
        EV_WRITE_SEL    = 3'd4,
        EV_NO_MATCH     = 3'd5,
        EV_BYTE_WRITTEN = 3'd6,
        EV_BYTE_TAKEN   = 3'd7
    } bus_event_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_ADDRESS = 4'b0010,
        PH_READ    = 4'b0100,
        PH_WRITE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                 scl_in;
        logic                 sda_in;
        logic [ByteWidth-1:0] read_byte;
    } sample_t;

    typedef struct packed {
        logic                 sda_pull_low;
        bus_event_t           bus_event;
        logic [ByteWidth-1:0] event_data;
    } result_t;

endpackage

// File: design/i2c_tbe_core.sv
// Bus state registers and the per-sample protocol decode.
module i2c_tbe_core
    import i2c_tbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  sample_t              sample,
    input  logic [AddrWidth-1:0] own_address,
    output result_t              result
);

    logic                  last_clock_reg, last_clock_next;
    logic                  last_data_reg, last_data_next;
    phase_t                phase_reg, phase_next;
    logic [CountWidth-1:0] bit_count_reg, bit_count_next;
    logic [ByteWidth-1:0]  shift_byte_reg, shift_byte_next;
    logic [AddrWidth-1:0]  addr_shift_reg, addr_shift_next;
    logic                  ack_pending_reg, ack_pending_next;
    logic                  ack_step_reg, ack_step_next;
    logic                  drive_low_reg, drive_low_next;

    always_comb
    begin
        logic                  sda;
        logic                  clocked;
        logic                  dchange;
        logic                  done;
        logic [ByteWidth-1:0]  src;
        logic [CountWidth-1:0] cnt;
        bus_event_t            ev;
        logic [ByteWidth-1:0]  data;

        last_clock_next  = last_clock_reg;
        last_data_next   = last_data_reg;
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_byte_next  = shift_byte_reg;
        addr_shift_next  = addr_shift_reg;
        ack_pending_next = ack_pending_reg;
        ack_step_next    = ack_step_reg;
        drive_low_next   = drive_low_reg;
        ev   = EV_NONE;
        data = '0;
        src  = '0;
        cnt  = '0;

        // open drain: we only see the line high if we are not pulling it
        sda     = sample.sda_in & ~drive_low_reg;
        clocked = (sample.scl_in != last_clock_reg);
        dchange = (sda != last_data_reg);
        done    = !(clocked || dchange);

        if (!done)
        begin
            last_clock_next = sample.scl_in;
            last_data_next  = sda;
        end

        if (!done && ack_pending_reg)
        begin
            if (!(clocked && !sample.scl_in))
            begin
                done = 1'b1;
            end
            else if (!ack_step_reg)
            begin
                drive_low_next = 1'b1;
                ack_step_next  = 1'b1;
                done           = 1'b1;
            end
            else
            begin
                // second falling edge ends the ACK and is handled as usual
                drive_low_next   = 1'b0;
                ack_step_next    = 1'b0;
                ack_pending_next = 1'b0;
            end
        end

        if (!done && dchange && !clocked && sample.scl_in)
        begin
            done = 1'b1;
            if (sda)
            begin
                drive_low_next = 1'b0;
                phase_next     = PH_IDLE;
                ev             = EV_STOP;
            end
            else
            begin
                phase_next      = PH_ADDRESS;
                bit_count_next  = '0;
                addr_shift_next = '0;
                ev              = EV_START;
            end
        end

        if (!done)
        begin
            case (phase_reg)
                PH_ADDRESS:
                begin
                    if (clocked && sample.scl_in)
                    begin
                        if (bit_count_reg < AddrBits)
                        begin
                            addr_shift_next = {addr_shift_reg[AddrWidth-2:0], sda};
                            bit_count_next  = bit_count_reg + 1'b1;
                        end
                        else if (addr_shift_reg == own_address)
                        begin
                            phase_next       = sda ? PH_READ : PH_WRITE;
                            bit_count_next   = '0;
                            ack_pending_next = 1'b1;
                            ev               = sda ? EV_READ_SEL : EV_WRITE_SEL;
                            data             = {1'b0, addr_shift_reg};
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            ev         = EV_NO_MATCH;
                            data       = {1'b0, addr_shift_reg};
                        end
                    end
                end
                PH_READ:
                begin
                    if (clocked && !sample.scl_in)
                    begin
                        src = shift_byte_reg;
                        if (bit_count_reg == '0)
                        begin
                            src = sample.read_byte;
                            ev  = EV_BYTE_TAKEN;
                        end
                        drive_low_next  = ~src[ByteWidth-1];
                        shift_byte_next = {src[ByteWidth-2:0], 1'b0};
                        cnt             = bit_count_reg + 1'b1;
                        bit_count_next  = cnt;
                        // ninth falling edge releases SDA for the master's ACK
                        if (cnt >= ReadSlot)
                        begin
                            bit_count_next = '0;
                            drive_low_next = 1'b0;
                        end
                    end
                end
                PH_WRITE:
                begin
                    if (clocked && sample.scl_in)
                    begin
                        src             = {shift_byte_reg[ByteWidth-2:0], sda};
                        shift_byte_next = src;
                        cnt             = bit_count_reg + 1'b1;
                        bit_count_next  = cnt;
                        if (cnt >= ByteBits)
                        begin
                            bit_count_next   = '0;
                            ack_pending_next = 1'b1;
                            ev               = EV_BYTE_WRITTEN;
                            data             = src;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        result.sda_pull_low = drive_low_next;
        result.bus_event    = ev;
        result.event_data   = data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_clock_reg  <= 1'b1;
            last_data_reg   <= 1'b1;
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            shift_byte_reg  <= '0;
            addr_shift_reg  <= '0;
            ack_pending_reg <= 1'b0;
            ack_step_reg    <= 1'b0;
            drive_low_reg   <= 1'b0;
        end
        else if (advance)
        begin
            last_clock_reg  <= last_clock_next;
            last_data_reg   <= last_data_next;
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_byte_reg  <= shift_byte_next;
            addr_shift_reg  <= addr_shift_next;
            ack_pending_reg <= ack_pending_next;
            ack_step_reg    <= ack_step_next;
            drive_low_reg   <= drive_low_next;
        end
    end

endmodule

// File: design/i2c_target_bus_engine_top.sv
// Top level of the I2C target bus engine: sample register, decode core, result register.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------
//  sample   | sample_valid / sample_ready  | sample_data  (sample_t)
//  result   | result_valid / result_ready  | result_data  (result_t)
//  config   | cfg_we                       | cfg_wdata    (own address)
//
// One sample per cycle sustained while results are taken; a sample passes through the
// sample register and then through the decode into the result register.
// rst_n clears the bus state, the own address and both valid flags.
// A stalled result holds the pipeline; the sample register still takes a
// transaction while the result waits if it is empty.
module i2c_target_bus_engine_top
    import i2c_tbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  sample_t              sample_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result_data,
    input  logic                 cfg_we,
    input  logic [AddrWidth-1:0] cfg_wdata
);

    logic                 in_valid_reg;
    sample_t              in_data_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;
    logic [AddrWidth-1:0] own_address_reg;
    logic                 advance;
    result_t              core_result;

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    i2c_tbe_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .sample      (in_data_reg),
        .own_address (own_address_reg),
        .result      (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            own_address_reg <= '0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                own_address_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            in_data_reg <= sample_data;
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the I2C target bus engine: bus waveforms in, drive and events out.
`timescale 1ns / 1ps

module testbench;
    import i2c_tbe_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int HoldEvery = 200;
    localparam int HoldCycles = 60;
    localparam int PhaseItems = 70;

    // read_byte fill for generated samples
    localparam int FillRandom = 0;
    localparam int FillZeros = 1;
    localparam int FillOnes = 2;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    sample_t              sample_data = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result_data;
    logic                 cfg_we = 1'b0;
    logic [AddrWidth-1:0] cfg_wdata = '0;

    sample_t pending_samples[$];
    result_t due_results[$];

    // mirror of the target's bus state
    logic [AddrWidth-1:0]  own_address_cfg = '0;
    logic                  line_clk = 1'b1;
    logic                  line_dat = 1'b1;
    phase_t                cur_phase = PH_IDLE;
    logic [CountWidth-1:0] bits_done = '0;
    logic [ByteWidth-1:0]  data_shift = '0;
    logic [AddrWidth-1:0]  addr_bits = '0;
    logic                  ack_wait = 1'b0;
    logic                  ack_second = 1'b0;
    logic                  pull_low = 1'b0;

    logic    sender_calm = 1'b1;
    logic    receiver_calm = 1'b1;
    int      fill_mode = FillRandom;
    bit      repeat_samples = 1'b0;
    int      send_gap = 0;
    int      ready_wait = 0;
    int      next_wait;
    int      results_seen = 0;
    int      error_count = 0;
    int      cycle_count = 0;
    result_t want;

    i2c_target_bus_engine_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic result_t target_response(input sample_t s);
        logic       scl;
        logic       sda;
        logic       clk_edge;
        logic       dat_edge;
        logic       handled;
        bus_event_t ev;
        logic [7:0] dat;
        ev = EV_NONE;
        dat = '0;
        scl = s.scl_in;
        sda = s.sda_in & ~pull_low;
        if (scl != line_clk || sda != line_dat)
        begin
            clk_edge = (scl != line_clk);
            dat_edge = (sda != line_dat);
            line_clk = scl;
            line_dat = sda;
            handled = 1'b0;
            // during ACK only falling SCL counts; the second one ends it
            if (ack_wait)
            begin
                handled = 1'b1;
                if (clk_edge && !scl)
                begin
                    if (!ack_second)
                    begin
                        pull_low = 1'b1;
                        ack_second = 1'b1;
                    end
                    else
                    begin
                        pull_low = 1'b0;
                        ack_second = 1'b0;
                        ack_wait = 1'b0;
                        handled = 1'b0;
                    end
                end
            end
            if (!handled)
            begin
                if (dat_edge && !clk_edge && scl)
                begin
                    if (sda)
                    begin
                        pull_low = 1'b0;
                        cur_phase = PH_IDLE;
                        ev = EV_STOP;
                    end
                    else
                    begin
                        cur_phase = PH_ADDRESS;
                        bits_done = '0;
                        addr_bits = '0;
                        ev = EV_START;
                    end
                end
                else
                begin
                    case (cur_phase)
                        PH_ADDRESS:
                        begin
                            if (clk_edge && scl)
                            begin
                                if (bits_done < AddrBits)
                                begin
                                    addr_bits = {addr_bits[AddrWidth-2:0], sda};
                                    bits_done = bits_done + 1'b1;
                                end
                                else if (addr_bits == own_address_cfg)
                                begin
                                    cur_phase = sda ? PH_READ : PH_WRITE;
                                    bits_done = '0;
                                    ack_wait = 1'b1;
                                    ev = sda ? EV_READ_SEL : EV_WRITE_SEL;
                                    dat = {1'b0, addr_bits};
                                end
                                else
                                begin
                                    cur_phase = PH_IDLE;
                                    ev = EV_NO_MATCH;
                                    dat = {1'b0, addr_bits};
                                end
                            end
                        end
                        PH_READ:
                        begin
                            if (clk_edge && !scl)
                            begin
                                if (bits_done == '0)
                                begin
                                    data_shift = s.read_byte;
                                    ev = EV_BYTE_TAKEN;
                                end
                                pull_low = ~data_shift[ByteWidth-1];
                                data_shift = data_shift << 1;
                                bits_done = bits_done + 1'b1;
                                // ninth slot is the master's ACK: let go of the line
                                if (bits_done >= ReadSlot)
                                begin
                                    bits_done = '0;
                                    pull_low = 1'b0;
                                end
                            end
                        end
                        PH_WRITE:
                        begin
                            if (clk_edge && scl)
                            begin
                                data_shift = {data_shift[ByteWidth-2:0], sda};
                                bits_done = bits_done + 1'b1;
                                if (bits_done >= ByteBits)
                                begin
                                    bits_done = '0;
                                    ack_wait = 1'b1;
                                    ev = EV_BYTE_WRITTEN;
                                    dat = data_shift;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        return '{sda_pull_low: pull_low, bus_event: ev, event_data: dat};
    endfunction

    // sender: one sample transaction at a time, random gap after each unless the sender is calm
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (sample_valid && sample_ready)
                due_results.insert(due_results.size(), target_response(sample_data));
            if (!sample_valid || sample_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample_valid <= 1'b1;
                    sample_data <= pending_samples.pop_front();
                    send_gap <= sender_calm ? 0 : $urandom_range(0, 4);
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result, random stalls unless calm, a long stall every HoldEvery results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            ready_wait <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (due_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: drive %b event %0d data %h",
                                 result_data.sda_pull_low, result_data.bus_event,
                                 result_data.event_data);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_data.sda_pull_low !== want.sda_pull_low ||
                        result_data.bus_event !== want.bus_event ||
                        result_data.event_data !== want.event_data)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"result %0d: expected drive %b event %0d data %h,",
                                      " got drive %b event %0d data %h"},
                                     results_seen, want.sda_pull_low, want.bus_event,
                                     want.event_data, result_data.sda_pull_low,
                                     result_data.bus_event, result_data.event_data);
                    end
                end
                results_seen++;
                if (results_seen % HoldEvery == 0)
                    next_wait = HoldCycles;
                else
                    next_wait = receiver_calm ? 0 : $urandom_range(0, 4);
                ready_wait <= next_wait;
                result_ready <= (next_wait == 0);
            end
            else if (ready_wait > 0)
            begin
                ready_wait <= ready_wait - 1;
                result_ready <= (ready_wait == 1);
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic put(input logic scl, input logic sda);
        sample_t s;
        s.scl_in = scl;
        s.sda_in = sda;
        case (fill_mode)
            FillZeros: s.read_byte = 8'h00;
            FillOnes:  s.read_byte = 8'hFF;
            default:   s.read_byte = 8'($urandom);
        endcase
        pending_samples.insert(pending_samples.size(), s);
        if (repeat_samples && $urandom_range(0, 7) == 0)
            pending_samples.insert(pending_samples.size(), s);
    endtask

    task automatic bus_start();
        put(1'b0, 1'b1);
        put(1'b1, 1'b1);
        put(1'b1, 1'b0);
        put(1'b0, 1'b0);
    endtask

    task automatic bus_stop();
        put(1'b0, 1'b0);
        put(1'b1, 1'b0);
        put(1'b1, 1'b1);
    endtask

    task automatic bus_bit(input logic b);
        put(1'b0, b);
        put(1'b1, b);
        put(1'b0, b);
    endtask

    task automatic bus_byte(input logic [7:0] v);
        for (int i = 7; i >= 0; i--)
            bus_bit(v[i]);
    endtask

    // well-formed access with random content; sometimes left without STOP
    task automatic bus_access();
        logic [AddrWidth-1:0] addr;
        logic                 rw;
        int                   n;
        addr = ($urandom_range(0, 3) != 0) ? own_address_cfg : 7'($urandom_range(0, 127));
        rw = 1'($urandom_range(0, 1));
        n = $urandom_range(0, 3);
        bus_start();
        bus_byte({addr, rw});
        bus_bit(1'b1);
        repeat (n)
        begin
            if (rw)
            begin
                bus_byte(8'hFF);
                bus_bit(1'($urandom_range(0, 1)));
            end
            else
            begin
                bus_byte(8'($urandom));
                bus_bit(1'b1);
            end
        end
        if ($urandom_range(0, 3) != 0)
            bus_stop();
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || sample_valid || due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_own_address(input logic [AddrWidth-1:0] a);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= a;
        own_address_cfg = a;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [AddrWidth-1:0] addr_list[5];
        int                   pick;
        addr_list = '{7'h7F, 7'h00, 7'($urandom), 7'($urandom), 7'h55};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: own address still at reset value 0
        bus_start();
        bus_byte(8'h00);
        bus_bit(1'b1);
        bus_byte(8'hFF);
        bus_bit(1'b1);
        bus_stop();
        put(1'b1, 1'b1);
        fill_mode = FillZeros;
        bus_start();
        bus_byte(8'h01);
        bus_bit(1'b1);
        bus_byte(8'hFF);
        bus_bit(1'b1);
        fill_mode = FillOnes;
        bus_byte(8'hFF);
        bus_bit(1'b0);
        bus_stop();
        fill_mode = FillRandom;
        bus_start();
        bus_byte({7'h7F, 1'b1});
        bus_bit(1'b1);
        bus_stop();
        drain();

        repeat_samples = 1'b1;
        for (int p = 0; p < 5; p++)
        begin
            set_own_address(addr_list[p]);
            sender_calm <= (p == 2);
            receiver_calm <= (p == 2 || p == 4);
            while (pending_samples.size() < PhaseItems)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                begin
                    bus_access();
                end
                else if (pick < 17)
                begin
                    // broken frame: START, up to 17 random bits, maybe STOP
                    bus_start();
                    repeat ($urandom_range(0, 17))
                        bus_bit(1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 1) != 0)
                        bus_stop();
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                        put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
